[rtl/core/mbup_pkg.sv]
// ----------------------------------------------------------------------------
// mbup_pkg
// Shared types and constants for the MIDI byte to USB-MIDI packet encoder:
// byte classes, the queue item and the USB-MIDI code index values.
// ----------------------------------------------------------------------------
`default_nettype none

package mbup_pkg;

  // queue sizing
  localparam int unsigned QueueDepth = 2;

  // MIDI byte values
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] TimeCodeQtr  = 8'hF1;
  localparam logic [7:0] SongPosition = 8'hF2;
  localparam logic [7:0] SongSelect   = 8'hF3;
  localparam logic [7:0] TuneRequest  = 8'hF6;
  localparam logic [7:0] RealtimeBase = 8'hF8;

  // status high nibbles of the one-data-byte channel messages
  localparam logic [3:0] ProgChangeHi = 4'hC;
  localparam logic [3:0] ChanPressHi  = 4'hD;

  // USB-MIDI code index numbers
  localparam logic [3:0] CinSysCommon2 = 4'h2;
  localparam logic [3:0] CinSysCommon3 = 4'h3;
  localparam logic [3:0] CinSingle1    = 4'h5;
  localparam logic [3:0] CinRealtime   = 4'hF;

  // data bytes still needed by an opened message
  localparam logic [1:0] NeedNone = 2'd0;
  localparam logic [1:0] NeedOne  = 2'd1;
  localparam logic [1:0] NeedTwo  = 2'd2;

  // class of one incoming byte
  typedef enum logic [2:0] {
    KindData,      // data byte, bit 7 clear
    KindRealtime,  // F8..FF, emitted at once
    KindSysex,     // F0, refused
    KindOpen,      // status that opens a message awaiting data
    KindTune,      // F6, emitted at once
    KindDrop       // F4, F5, F7: abandon and drop
  } kind_e;

  // classified byte as it travels from front to back
  typedef struct packed {
    kind_e      kind;
    logic [1:0] need;
    logic [7:0] value;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/mbup_front.sv]
// ----------------------------------------------------------------------------
// mbup_front
// Input side: accepts MIDI bytes and classifies each one into a queue item.
// ----------------------------------------------------------------------------
`default_nettype none

module mbup_front (
  input  logic                 in_valid_i,
  input  logic [7:0]           midi_byte_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output mbup_pkg::item_t      q_item_o
);

  logic [3:0] hi;

  assign hi = midi_byte_i[7:4];

  // input transfer whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // byte classification
  always_comb begin
    q_item_o.kind  = mbup_pkg::KindDrop;
    q_item_o.need  = mbup_pkg::NeedNone;
    q_item_o.value = midi_byte_i;
    if (!midi_byte_i[7]) begin
      q_item_o.kind = mbup_pkg::KindData;
    end else if (midi_byte_i >= mbup_pkg::RealtimeBase) begin
      q_item_o.kind = mbup_pkg::KindRealtime;
    end else if (midi_byte_i == mbup_pkg::SysexStart) begin
      q_item_o.kind = mbup_pkg::KindSysex;
    end else if (midi_byte_i < mbup_pkg::SysexStart) begin
      q_item_o.kind = mbup_pkg::KindOpen;
      q_item_o.need = (hi == mbup_pkg::ProgChangeHi || hi == mbup_pkg::ChanPressHi)
                      ? mbup_pkg::NeedOne : mbup_pkg::NeedTwo;
    end else if (midi_byte_i == mbup_pkg::TimeCodeQtr ||
                 midi_byte_i == mbup_pkg::SongSelect) begin
      q_item_o.kind = mbup_pkg::KindOpen;
      q_item_o.need = mbup_pkg::NeedOne;
    end else if (midi_byte_i == mbup_pkg::SongPosition) begin
      q_item_o.kind = mbup_pkg::KindOpen;
      q_item_o.need = mbup_pkg::NeedTwo;
    end else if (midi_byte_i == mbup_pkg::TuneRequest) begin
      q_item_o.kind = mbup_pkg::KindTune;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mbup_fifo.sv]
// ----------------------------------------------------------------------------
// mbup_fifo
// Short flop-based queue between the classifier and the packet builder.
// ----------------------------------------------------------------------------
`default_nettype none

module mbup_fifo #(
  parameter int unsigned Depth = mbup_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbup_pkg::item_t push_item_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_stall_i,
  output mbup_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mbup_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign full_o      = (count_q == FullCnt);
  assign pop_valid_o = (count_q != '0);
  assign pop         = pop_valid_o && !pop_stall_i;
  assign pop_item_o  = entry_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mbup_back.sv]
// ----------------------------------------------------------------------------
// mbup_back
// Packet builder: holds the pending message, collects data bytes and
// loads finished USB-MIDI event packets into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbup_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_stall_o,
  input  mbup_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [3:0]      code_index_o,
  output logic [7:0]      status_byte_o,
  output logic [6:0]      data_first_o,
  output logic [6:0]      data_second_o,
  output logic            sysex_refused_o
);

  logic [7:0] held_q, held_d;
  logic [6:0] first_q, first_d;
  logic [1:0] need_q, need_d;

  logic       out_valid_q, out_valid_d;
  logic [3:0] cin_q;
  logic [7:0] status_q;
  logic [6:0] d1_q;
  logic [6:0] d2_q;
  logic       refused_q;

  logic       pop;
  logic       emit;
  logic [3:0] cin;
  logic [7:0] status;
  logic [6:0] d1;
  logic [6:0] d2;
  logic       refused;
  logic       one_data;
  logic [3:0] held_code;

  // one queue item per cycle while the output register is free or draining
  assign q_stall_o = out_valid_q && out_stall_i;
  assign pop       = q_valid_i && !q_stall_o;

  // message shape from the held status
  assign one_data = (held_q[7:4] == mbup_pkg::ProgChangeHi) ||
                    (held_q[7:4] == mbup_pkg::ChanPressHi) ||
                    (held_q == mbup_pkg::TimeCodeQtr) ||
                    (held_q == mbup_pkg::SongSelect);

  always_comb begin
    if (held_q < mbup_pkg::SysexStart) begin
      held_code = held_q[7:4];
    end else if (held_q == mbup_pkg::SongPosition) begin
      held_code = mbup_pkg::CinSysCommon3;
    end else if (held_q == mbup_pkg::TuneRequest) begin
      held_code = mbup_pkg::CinSingle1;
    end else begin
      held_code = mbup_pkg::CinSysCommon2;
    end
  end

  // pending message update and packet assembly
  always_comb begin
    held_d  = held_q;
    first_d = first_q;
    need_d  = need_q;
    emit    = 1'b0;
    cin     = '0;
    status  = '0;
    d1      = '0;
    d2      = '0;
    refused = 1'b0;
    if (pop) begin
      case (q_item_i.kind)
        mbup_pkg::KindData: begin
          if (need_q == mbup_pkg::NeedNone || held_q == '0) begin
            held_d  = '0;
            first_d = '0;
            need_d  = mbup_pkg::NeedNone;
          end else if (need_q >= mbup_pkg::NeedTwo) begin
            first_d = q_item_i.value[6:0];
            need_d  = mbup_pkg::NeedOne;
          end else begin
            emit    = 1'b1;
            cin     = held_code;
            status  = held_q;
            d1      = one_data ? q_item_i.value[6:0] : first_q;
            d2      = one_data ? 7'd0 : q_item_i.value[6:0];
            held_d  = '0;
            first_d = '0;
            need_d  = mbup_pkg::NeedNone;
          end
        end
        mbup_pkg::KindRealtime: begin
          emit   = 1'b1;
          cin    = mbup_pkg::CinRealtime;
          status = q_item_i.value;
        end
        mbup_pkg::KindSysex: begin
          emit    = 1'b1;
          refused = 1'b1;
          held_d  = '0;
          first_d = '0;
          need_d  = mbup_pkg::NeedNone;
        end
        mbup_pkg::KindOpen: begin
          held_d  = q_item_i.value;
          first_d = '0;
          need_d  = q_item_i.need;
        end
        mbup_pkg::KindTune: begin
          emit    = 1'b1;
          cin     = mbup_pkg::CinSingle1;
          status  = q_item_i.value;
          held_d  = '0;
          first_d = '0;
          need_d  = mbup_pkg::NeedNone;
        end
        default: begin
          held_d  = '0;
          first_d = '0;
          need_d  = mbup_pkg::NeedNone;
        end
      endcase
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      first_q     <= '0;
      need_q      <= mbup_pkg::NeedNone;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      first_q     <= first_d;
      need_q      <= need_d;
      out_valid_q <= out_valid_d;
    end
  end

  // packet payload
  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      cin_q     <= cin;
      status_q  <= status;
      d1_q      <= d1;
      d2_q      <= d2;
      refused_q <= refused;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_index_o    = cin_q;
  assign status_byte_o   = status_q;
  assign data_first_o    = d1_q;
  assign data_second_o   = d2_q;
  assign sysex_refused_o = refused_q;

  // a refused sysex packet carries all-zero fields
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && refused_q |->
      cin_q == '0 && status_q == '0 && d1_q == '0 && d2_q == '0)
    else $error("refused packet with nonzero fields");

  // a pending message always has a status byte behind it
  a_need_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q != mbup_pkg::NeedNone |-> held_q[7])
    else $error("data bytes awaited without a held status");

  // never more than two data bytes awaited
  a_need_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q <= mbup_pkg::NeedTwo)
    else $error("illegal data byte count");

  // a stalled packet is not overwritten by a queue pop
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !pop)
    else $error("queue popped while output packet is stalled");

endmodule

`default_nettype wire

[rtl/core/midi_byte_to_usb_packet_core.sv]
// ----------------------------------------------------------------------------
// midi_byte_to_usb_packet_core
// Encodes a raw MIDI byte stream into USB-MIDI 1.0 event packets, cable 0.
// ----------------------------------------------------------------------------
// Path: the byte that ends a packet is stored in the classifier queue, then
// loaded into the packet builder output register.
// Throughput: one byte per cycle while the queue has room; the builder takes
// one queued byte each cycle while the output register is free or draining.
// Reset: asynchronous, active low; clears the pending message, the queue and
// the output valid.
`default_nettype none

module midi_byte_to_usb_packet_core #(
  parameter int unsigned QueueDepth = mbup_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] midi_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] code_index_o,
  output logic [7:0] status_byte_o,
  output logic [6:0] data_first_o,
  output logic [6:0] data_second_o,
  output logic       sysex_refused_o
);

  logic            q_full;
  logic            q_push;
  mbup_pkg::item_t q_push_item;
  logic            q_valid;
  logic            q_stall;
  mbup_pkg::item_t q_pop_item;

  // byte classifier
  mbup_front u_front (
    .in_valid_i  (in_valid_i),
    .midi_byte_i (midi_byte_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_push_item)
  );

  // decoupling queue
  mbup_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_stall_i (q_stall),
    .pop_item_o  (q_pop_item)
  );

  // packet builder and output register
  mbup_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_stall_o       (q_stall),
    .q_item_i        (q_pop_item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_index_o    (code_index_o),
    .status_byte_o   (status_byte_o),
    .data_first_o    (data_first_o),
    .data_second_o   (data_second_o),
    .sysex_refused_o (sysex_refused_o)
  );

endmodule

`default_nettype wire
